FILE: design/assert_macros.svh
// assertion macros used by the port level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define PKLT_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("pklt assertion failed");

// expression must never be true outside reset
`define PKLT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("pklt forbidden condition seen");

`endif

FILE: design/pklt_pkg.sv
// types and constants of the pressed key list tracker
`timescale 1ns / 1ps
package pklt_pkg;

	localparam logic [7:0] EMPTY_CODE = 8'd255;

	localparam logic KIND_SLOT   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef struct packed {
		logic load_event;
		logic latch_match;
		logic apply_update;
		logic emit_load;
	} pklt_cmd_t;

	typedef struct packed {
		logic will_change;
		logic out_free;
		logic emit_last;
	} pklt_status_t;

endpackage

FILE: design/pklt_ctrl.sv
// controller state machine of the pressed key list tracker
`timescale 1ns / 1ps
module pklt_ctrl
	import pklt_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  pklt_status_t status,
	output pklt_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_UPDATE,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   in_ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready_q) begin
						state_q    <= ST_MATCH;
						in_ready_q <= 1'b0;
					end
				end
				ST_MATCH: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (status.will_change) begin
						state_q <= ST_EMIT;
					end else begin
						state_q    <= ST_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				ST_EMIT: begin
					if (status.out_free && status.emit_last) begin
						state_q    <= ST_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign in_ready = in_ready_q;

	always_comb begin
		cmd              = '0;
		cmd.load_event   = (state_q == ST_IDLE) && in_valid && in_ready_q;
		cmd.latch_match  = (state_q == ST_MATCH);
		cmd.apply_update = (state_q == ST_UPDATE);
		cmd.emit_load    = (state_q == ST_EMIT) && status.out_free;
	end

endmodule

FILE: design/pklt_datapath.sv
// key slot storage, match, compaction and output register
`timescale 1ns / 1ps
module pklt_datapath
	import pklt_pkg::*;
#(
	parameter int KEY_SLOTS = 6
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	input  logic [7:0]   key_code,
	input  logic         modifier_flag,
	input  logic         press_flag,
	input  pklt_cmd_t    cmd,
	output pklt_status_t status,
	output logic         out_valid,
	input  logic         out_ready,
	output logic         report_kind,
	output logic [2:0]   slot_index,
	output logic [7:0]   slot_code,
	output logic         slot_modifier,
	output logic         slot_pressed,
	output logic [2:0]   held_count,
	output logic         last_item
);

	localparam int IW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
	localparam int CW = $clog2(KEY_SLOTS + 1);

	logic [7:0]    code_q [KEY_SLOTS];
	logic          mod_q  [KEY_SLOTS];
	logic [CW-1:0] total_q;
	logic          report_en_q;

	logic [7:0]    ev_code_q;
	logic          ev_mod_q;
	logic          ev_press_q;

	logic          hit_q;
	logic [IW-1:0] found_q;
	logic [IW-1:0] emit_idx_q;

	logic          match_any;
	logic [IW-1:0] match_idx;
	logic          do_remove;
	logic          do_append;
	logic          emit_occ;

	logic          out_valid_q;
	logic          out_kind_q;
	logic [2:0]    out_idx_q;
	logic [7:0]    out_code_q;
	logic          out_mod_q;
	logic          out_pressed_q;
	logic [2:0]    out_count_q;
	logic          out_last_q;

	// parallel compare over occupied slots, first hit wins
	always_comb begin
		match_any = 1'b0;
		match_idx = '0;
		for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
			if ((CW'(i) < total_q) && (code_q[i] == ev_code_q) && (mod_q[i] == ev_mod_q)) begin
				match_any = 1'b1;
				match_idx = IW'(i);
			end
		end
	end

	assign do_remove = hit_q && !ev_press_q;
	assign do_append = !hit_q && ev_press_q && (total_q < CW'(KEY_SLOTS));

	assign status.will_change = do_remove || do_append;
	assign status.out_free    = !out_valid_q || out_ready;
	assign status.emit_last   = !report_en_q || (emit_idx_q == IW'(KEY_SLOTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_en_q <= 1'b1;
		end else if (cfg_we) begin
			report_en_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_event) begin
			ev_code_q  <= key_code;
			ev_mod_q   <= modifier_flag;
			ev_press_q <= press_flag;
		end
		if (cmd.latch_match) begin
			hit_q   <= match_any;
			found_q <= match_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cmd.apply_update) begin
			if (do_remove) begin
				total_q <= total_q - CW'(1);
			end else if (do_append) begin
				total_q <= total_q + CW'(1);
			end
		end
	end

	// slot registers: remove shifts later entries forward, append writes the tail
	for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_slot
		logic [7:0] next_code;
		logic       next_mod;

		if (g < KEY_SLOTS - 1) begin : g_mid
			assign next_code = code_q[g + 1];
			assign next_mod  = mod_q[g + 1];
		end else begin : g_end
			assign next_code = EMPTY_CODE;
			assign next_mod  = 1'b0;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				code_q[g] <= EMPTY_CODE;
				mod_q[g]  <= 1'b0;
			end else if (cmd.apply_update) begin
				if (do_remove && (IW'(g) >= found_q)) begin
					code_q[g] <= next_code;
					mod_q[g]  <= next_mod;
				end else if (do_append && (CW'(g) == total_q)) begin
					code_q[g] <= ev_code_q;
					mod_q[g]  <= ev_mod_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply_update) begin
			emit_idx_q <= '0;
		end else if (cmd.emit_load) begin
			emit_idx_q <= emit_idx_q + IW'(1);
		end
	end

	assign emit_occ = ({1'b0, emit_idx_q} < (IW + 1)'(total_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			out_count_q <= 3'(total_q);
			if (report_en_q) begin
				out_kind_q    <= KIND_SLOT;
				out_idx_q     <= 3'(emit_idx_q);
				out_code_q    <= emit_occ ? code_q[emit_idx_q] : EMPTY_CODE;
				out_mod_q     <= emit_occ ? mod_q[emit_idx_q] : 1'b0;
				out_pressed_q <= emit_occ;
				out_last_q    <= (emit_idx_q == IW'(KEY_SLOTS - 1));
			end else begin
				out_kind_q    <= KIND_STATUS;
				out_idx_q     <= 3'd0;
				out_code_q    <= EMPTY_CODE;
				out_mod_q     <= 1'b0;
				out_pressed_q <= 1'b0;
				out_last_q    <= 1'b1;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign report_kind   = out_kind_q;
	assign slot_index    = out_idx_q;
	assign slot_code     = out_code_q;
	assign slot_modifier = out_mod_q;
	assign slot_pressed  = out_pressed_q;
	assign held_count    = out_count_q;
	assign last_item     = out_last_q;

endmodule

FILE: design/pressed_key_list_tracker.sv
// top level of the pressed key list tracker
`timescale 1ns / 1ps
// Keeps the ordered list of held keys (oldest first) for a KEY_SLOTS-key
// rollover HID report. One key event is taken at a time: a transfer on the
// input is followed by a parallel match over the occupied slots (ST_MATCH)
// and an update state (ST_UPDATE) that removes (shifting later slots forward)
// or appends. An event that changes nothing is done after ST_UPDATE. A change
// then sends KEY_SLOTS slot transfers, one per cycle from the output register
// while the output is not stalled, or one status transfer when report_enable
// is 0, and in_ready returns as the last result enters the output register.
// report_enable resets to 1; the user must write it through cfg_we/cfg_wdata
// only while no event is in flight, which the block itself does not enforce.
module pressed_key_list_tracker
	import pklt_pkg::*;
#(
	parameter int KEY_SLOTS = 6
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] key_code,
	input  logic       modifier_flag,
	input  logic       press_flag,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       report_kind,
	output logic [2:0] slot_index,
	output logic [7:0] slot_code,
	output logic       slot_modifier,
	output logic       slot_pressed,
	output logic [2:0] held_count,
	output logic       last_item
);

	pklt_cmd_t    cmd;
	pklt_status_t status;

	pklt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	pklt_datapath #(
		.KEY_SLOTS (KEY_SLOTS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.key_code      (key_code),
		.modifier_flag (modifier_flag),
		.press_flag    (press_flag),
		.cmd           (cmd),
		.status        (status),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.report_kind   (report_kind),
		.slot_index    (slot_index),
		.slot_code     (slot_code),
		.slot_modifier (slot_modifier),
		.slot_pressed  (slot_pressed),
		.held_count    (held_count),
		.last_item     (last_item)
	);

endmodule

FILE: design/pklt_checker.sv
// port level checks of the pressed key list tracker
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pklt_checker
	import pklt_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       report_kind,
	input logic [2:0] slot_index,
	input logic [7:0] slot_code,
	input logic       slot_modifier,
	input logic       slot_pressed,
	input logic [2:0] held_count,
	input logic       last_item
);

	// a stalled transfer keeps its payload
	`PKLT_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(slot_code) && $stable(slot_index) && $stable(last_item))

	// status item has a fixed empty payload and ends the event
	`PKLT_ASSERT(a_status_form, clk, arst_n, out_valid && (report_kind == KIND_STATUS) |-> last_item && !slot_pressed && !slot_modifier && (slot_index == 3'd0) && (slot_code == EMPTY_CODE))

	// occupied slots lie below the held count
	`PKLT_ASSERT(a_occupied_slot, clk, arst_n, out_valid && (report_kind == KIND_SLOT) && slot_pressed |-> slot_index < held_count)

	// no new event is taken while a report is mid-way
	`PKLT_NEVER(a_busy_mid_report, clk, arst_n, out_valid && !last_item && in_ready)

endmodule

bind pressed_key_list_tracker pklt_checker u_pklt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.report_kind   (report_kind),
	.slot_index    (slot_index),
	.slot_code     (slot_code),
	.slot_modifier (slot_modifier),
	.slot_pressed  (slot_pressed),
	.held_count    (held_count),
	.last_item     (last_item)
);
